// ===== hw/rtl/tfn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared defaults for the triangle face normal core.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int TFN_COORD_WIDTH = 24;
    localparam int TFN_UNIT_WIDTH  = 16;

endpackage

// ===== hw/rtl/tfn_root_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_root_step
// One bit of the scaled square root for all three normal components.
// Keeps remainder r = 2^(2U) n^2 - m^2 L and d = m L, and tries bit J of m.
// ----------------------------------------------------------------------------
module tfn_root_step
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH = TFN_COORD_WIDTH,
    parameter int UNIT_WIDTH  = TFN_UNIT_WIDTH,
    parameter int J           = 0
) (
    input  logic                                              i_clk,
    input  logic                                              i_en,
    input  logic [4*COORD_WIDTH+3:0]                          i_len,
    input  logic [2:0]                                        i_neg,
    input  logic [2:0][4*COORD_WIDTH+2*UNIT_WIDTH+4:0]        i_rem,
    input  logic [2:0][4*COORD_WIDTH+UNIT_WIDTH+3:0]          i_dm,
    input  logic [2:0][UNIT_WIDTH-1:0]                        i_m,
    output logic [4*COORD_WIDTH+3:0]                          o_len,
    output logic [2:0]                                        o_neg,
    output logic [2:0][4*COORD_WIDTH+2*UNIT_WIDTH+4:0]        o_rem,
    output logic [2:0][4*COORD_WIDTH+UNIT_WIDTH+3:0]          o_dm,
    output logic [2:0][UNIT_WIDTH-1:0]                        o_m
);

    localparam int LW = 4*COORD_WIDTH + 4;
    localparam int RW = 4*COORD_WIDTH + 2*UNIT_WIDTH + 5;
    localparam int DW = LW + UNIT_WIDTH;

    logic [LW-1:0]          r_len;
    logic [2:0]             r_neg;
    logic [2:0][RW-1:0]     r_rem, n_rem;
    logic [2:0][DW-1:0]     r_dm, n_dm;
    logic [2:0][UNIT_WIDTH-1:0] r_m, n_m;
    logic [2:0][RW-1:0]     w_trial;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_trial[c] = (RW'(i_dm[c]) << (J+1)) + (RW'(i_len) << (2*J));
            if (w_trial[c] <= i_rem[c]) begin
                n_rem[c] = i_rem[c] - w_trial[c];
                n_dm[c]  = i_dm[c] + (DW'(i_len) << J);
                n_m[c]   = i_m[c] | (UNIT_WIDTH'(1) << J);
            end else begin
                n_rem[c] = i_rem[c];
                n_dm[c]  = i_dm[c];
                n_m[c]   = i_m[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len <= i_len;
            r_neg <= i_neg;
            r_rem <= n_rem;
            r_dm  <= n_dm;
            r_m   <= n_m;
        end
    end

    assign o_len = r_len;
    assign o_neg = r_neg;
    assign o_rem = r_rem;
    assign o_dm  = r_dm;
    assign o_m   = r_m;

endmodule

// ===== hw/rtl/triangle_face_normal_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal_core
// Unit face normal of a triangle from three Q12.12 vertices, Q1.15 result.
// ----------------------------------------------------------------------------
// Takes one triangle per clock unless back pressure fills the pipeline.
// Registered stages form the edges, the exact cross product, its squares
// and the squared length, then a restoring square-root step for each
// result bit runs on all three components, and the last stage rounds,
// saturates and applies the sign. Each stage moves on its own when the
// next one is free, so bubbles close up under back pressure. A zero cross
// product gives the zero vector with tuser set.
// ----------------------------------------------------------------------------
module triangle_face_normal_core
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH = TFN_COORD_WIDTH,
    parameter int UNIT_WIDTH  = TFN_UNIT_WIDTH
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]       i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  logic                                     i_m_axis_tready,
    // unit_x, unit_y, unit_z
    output logic [((3*UNIT_WIDTH+7)/8)*8-1:0]        o_m_axis_tdata,
    // degenerate
    output logic                                     o_m_axis_tuser
);

    localparam int W    = COORD_WIDTH;
    localparam int U    = UNIT_WIDTH;
    localparam int E    = W + 1;
    localparam int PW   = 2*E;
    localparam int NW   = 2*W + 3;
    localparam int MW   = 2*W + 1;
    localparam int LOW  = W + 1;
    localparam int HIW  = MW - LOW;
    localparam int N2W  = 4*W + 2;
    localparam int LW   = 4*W + 4;
    localparam int RW   = 4*W + 2*U + 5;
    localparam int DW   = LW + U;
    localparam int OW   = ((3*U+7)/8)*8;
    localparam int NST  = U + 7;

    logic [NST-1:0] r_vld, n_vld;
    logic [NST-1:0] w_en;

    assign w_en[NST-1] = !r_vld[NST-1] || i_m_axis_tready;
    genvar k;
    generate
        for (k = 0; k < NST-1; k++) begin : g_en
            assign w_en[k] = !r_vld[k] || w_en[k+1];
        end
    endgenerate

    always_comb begin
        for (int s = 0; s < NST; s++) begin
            if (!w_en[s]) begin
                n_vld[s] = r_vld[s];
            end else if (s == 0) begin
                n_vld[s] = i_s_axis_tvalid;
            end else begin
                n_vld[s] = r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[NST-1];

    // edges
    logic signed [W-1:0] w_crd [0:8];
    logic signed [E-1:0] r_e1 [0:2];
    logic signed [E-1:0] r_e2 [0:2];

    always_comb begin
        for (int f = 0; f < 9; f++) begin
            w_crd[f] = $signed(i_s_axis_tdata[f*W +: W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int c = 0; c < 3; c++) begin
                r_e1[c] <= E'(w_crd[3+c]) - E'(w_crd[c]);
                r_e2[c] <= E'(w_crd[6+c]) - E'(w_crd[c]);
            end
        end
    end

    // cross product terms
    logic signed [PW-1:0] r_p [0:2];
    logic signed [PW-1:0] r_q [0:2];

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int c = 0; c < 3; c++) begin
                r_p[c] <= PW'(r_e1[(c+1)%3]) * PW'(r_e2[(c+2)%3]);
                r_q[c] <= PW'(r_e1[(c+2)%3]) * PW'(r_e2[(c+1)%3]);
            end
        end
    end

    // normal magnitude and sign
    logic signed [NW-1:0] w_n [0:2];
    logic [MW-1:0]        r_nmag [0:2];
    logic [2:0]           r_sg2;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_n[c] = NW'(r_p[c]) - NW'(r_q[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int c = 0; c < 3; c++) begin
                r_sg2[c]  <= w_n[c][NW-1];
                r_nmag[c] <= w_n[c][NW-1] ? MW'(-w_n[c]) : MW'(w_n[c]);
            end
        end
    end

    // partial squares
    logic [2*HIW-1:0]     r_hh [0:2];
    logic [HIW+LOW-1:0]   r_hl [0:2];
    logic [2*LOW-1:0]     r_ll [0:2];
    logic [2:0]           r_sg3;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_sg3 <= r_sg2;
            for (int c = 0; c < 3; c++) begin
                r_hh[c] <= (2*HIW)'(r_nmag[c][MW-1:LOW]) * (2*HIW)'(r_nmag[c][MW-1:LOW]);
                r_hl[c] <= (HIW+LOW)'(r_nmag[c][MW-1:LOW])
                         * (HIW+LOW)'(r_nmag[c][LOW-1:0]);
                r_ll[c] <= (2*LOW)'(r_nmag[c][LOW-1:0]) * (2*LOW)'(r_nmag[c][LOW-1:0]);
            end
        end
    end

    // component squares
    logic [N2W-1:0] r_n2 [0:2];
    logic [2:0]     r_sg4;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_sg4 <= r_sg3;
            for (int c = 0; c < 3; c++) begin
                r_n2[c] <= (N2W'(r_hh[c]) << (2*LOW)) + (N2W'(r_hl[c]) << (LOW+1))
                         + N2W'(r_ll[c]);
            end
        end
    end

    // squared length
    logic [LW-1:0]  r_len;
    logic [N2W-1:0] r_n2b [0:2];
    logic [2:0]     r_sg5;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_sg5 <= r_sg4;
            r_len <= LW'(r_n2[0]) + LW'(r_n2[1]) + LW'(r_n2[2]);
            for (int c = 0; c < 3; c++) begin
                r_n2b[c] <= r_n2[c];
            end
        end
    end

    // root steps, most significant bit first
    logic [LW-1:0]           w_len [0:U];
    logic [2:0]              w_neg [0:U];
    logic [2:0][RW-1:0]      w_rem [0:U];
    logic [2:0][DW-1:0]      w_dm  [0:U];
    logic [2:0][U-1:0]       w_m   [0:U];

    assign w_len[0] = r_len;
    assign w_neg[0] = r_sg5;
    assign w_dm[0]  = '0;
    assign w_m[0]   = '0;

    generate
        for (k = 0; k < 3; k++) begin : g_seed
            assign w_rem[0][k] = RW'(r_n2b[k]) << (2*U);
        end
    endgenerate

    generate
        for (k = 0; k < U; k++) begin : g_step
            tfn_root_step #(
                .COORD_WIDTH(COORD_WIDTH),
                .UNIT_WIDTH (UNIT_WIDTH),
                .J          (U-1-k)
            ) u_step (
                .i_clk (i_clk),
                .i_en  (w_en[6+k]),
                .i_len (w_len[k]),
                .i_neg (w_neg[k]),
                .i_rem (w_rem[k]),
                .i_dm  (w_dm[k]),
                .i_m   (w_m[k]),
                .o_len (w_len[k+1]),
                .o_neg (w_neg[k+1]),
                .o_rem (w_rem[k+1]),
                .o_dm  (w_dm[k+1]),
                .o_m   (w_m[k+1])
            );
        end
    endgenerate

    // round, saturate, sign
    logic [OW-1:0] r_out, n_out;
    logic          r_deg, n_deg;
    logic [U:0]    w_mp1 [0:2];
    logic [U-1:0]  w_q   [0:2];

    always_comb begin
        n_out = '0;
        n_deg = (w_len[U] == '0);
        for (int c = 0; c < 3; c++) begin
            w_mp1[c] = {1'b0, w_m[U][c]} + (U+1)'(1);
            w_q[c]   = w_mp1[c][U:1];
            if (w_q[c][U-1]) begin
                w_q[c] = {1'b0, {(U-1){1'b1}}};
            end
            if (!n_deg) begin
                n_out[c*U +: U] = w_neg[U][c] ? -w_q[c] : w_q[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NST-1]) begin
            r_out <= n_out;
            r_deg <= n_deg;
        end
    end

    assign o_m_axis_tdata = r_out;
    assign o_m_axis_tuser = r_deg;

endmodule
